// ===== src/lfu_pkg.sv =====
// Shared constants and item types for the LFU cache with LRU tie-break.
package lfu_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CNT_W       = 32;
    localparam int CAP_W       = 5;
    localparam int RANK_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int FILL_W      = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = (CAP_W > FILL_W) ? CAP_W : FILL_W;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Register index, taken from paddr above the byte offset
    localparam logic [CFG_ADDR_W-3:0] REG_CAPACITY = '0;

    typedef enum logic {
        ACT_GET = 1'b0,
        ACT_PUT = 1'b1
    } action_t;

    typedef struct packed {
        action_t          action;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } out_item_t;

    typedef logic [MAX_ENTRIES-1:0]                 slot_vec_t;
    typedef logic [MAX_ENTRIES-1:0][KEY_W-1:0]      key_arr_t;
    typedef logic [MAX_ENTRIES-1:0][VAL_W-1:0]      val_arr_t;
    typedef logic [MAX_ENTRIES-1:0][CNT_W-1:0]      cnt_arr_t;
    typedef logic [MAX_ENTRIES-1:0][RANK_W-1:0]     rank_arr_t;

endpackage

// ===== src/lfu_cache_with_lru_tiebreak_unit.sv =====
// Top level: fully associative LFU key/value cache with LRU tie-break.
//
// Each item (get or put) is taken into an input register and resolved, once
// the output register is free, against all slots at once: parallel key match,
// a pairwise count/recency compare that names the replacement victim, and the
// table update, all landing together with the result in the output register
// that drives m_item. One item per clock cycle is sustained while m_ready is
// high. The capacity register (byte address 0) limits how many slots may be
// used; zero turns puts into lookups only. Slot contents are invalid after
// reset, with no clearing pass.
module lfu_cache_with_lru_tiebreak_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  lfu_pkg::in_item_t                    s_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output lfu_pkg::out_item_t                   m_item,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lfu_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [lfu_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [lfu_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    logic                          in_valid_reg;
    lfu_pkg::in_item_t             in_item_reg;
    logic                          out_valid_reg;
    lfu_pkg::out_item_t            out_item_reg;
    logic [lfu_pkg::CAP_W-1:0]     cap_reg;

    lfu_pkg::slot_vec_t            valid_reg, valid_next;
    lfu_pkg::key_arr_t             key_reg, key_next;
    lfu_pkg::val_arr_t             value_reg, value_next;
    lfu_pkg::cnt_arr_t             count_reg, count_next;
    lfu_pkg::rank_arr_t            rank_reg, rank_next;

    logic                          out_free;
    logic                          proceed;
    logic                          is_put;
    lfu_pkg::slot_vec_t            match;
    lfu_pkg::slot_vec_t            found_oh;
    lfu_pkg::slot_vec_t            free_oh;
    lfu_pkg::slot_vec_t            victim_oh;
    lfu_pkg::slot_vec_t            slot_oh;
    logic                          found;
    logic [lfu_pkg::VAL_W-1:0]     rd_value;
    logic [lfu_pkg::KEY_W-1:0]     victim_key;
    logic [lfu_pkg::RANK_W-1:0]    found_rank;
    logic [lfu_pkg::RANK_W-1:0]    victim_rank;
    logic [lfu_pkg::FILL_W-1:0]    fill;
    logic [lfu_pkg::CMP_W-1:0]     cap_w;
    logic [lfu_pkg::CMP_W-1:0]     cap_eff;
    logic                          cap_zero;
    logic                          do_touch;
    logic                          do_insert;
    logic                          evict;
    lfu_pkg::out_item_t            result;
    logic                          cfg_wr;
    logic                          cfg_sel;

    // Handshake
    assign out_free = !out_valid_reg || m_ready;
    assign proceed  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || proceed;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_item_reg;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[lfu_pkg::CFG_ADDR_W-1:2] == lfu_pkg::REG_CAPACITY);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
    assign prdata  = cfg_sel ? lfu_pkg::CFG_DATA_W'(cap_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lfu_pkg::CAP_RESET;
        end else if (cfg_wr) begin
            cap_reg <= pwdata[lfu_pkg::CAP_W-1:0];
        end
    end

    // Input and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= proceed;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed) begin
            out_item_reg <= result;
        end
    end

    // Lookup
    assign is_put = (in_item_reg.action == lfu_pkg::ACT_PUT);

    always_comb begin
        for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
            match[i] = valid_reg[i] && (key_reg[i] == in_item_reg.key);
        end
    end

    assign found_oh = match & (~match + 1'b1);
    assign free_oh  = ~valid_reg & (valid_reg + 1'b1);
    assign found    = |match;

    lfu_victim_pick u_victim (
        .valid     (valid_reg),
        .count     (count_reg),
        .rank      (rank_reg),
        .victim_oh (victim_oh)
    );

    always_comb begin
        rd_value    = '0;
        victim_key  = '0;
        found_rank  = '0;
        victim_rank = '0;
        fill        = '0;
        for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
            rd_value    = rd_value    | ({lfu_pkg::VAL_W{found_oh[i]}}  & value_reg[i]);
            found_rank  = found_rank  | ({lfu_pkg::RANK_W{found_oh[i]}} & rank_reg[i]);
            victim_key  = victim_key  | ({lfu_pkg::KEY_W{victim_oh[i]}}  & key_reg[i]);
            victim_rank = victim_rank | ({lfu_pkg::RANK_W{victim_oh[i]}} & rank_reg[i]);
            fill        = fill + lfu_pkg::FILL_W'(valid_reg[i]);
        end
    end

    assign cap_w     = lfu_pkg::CMP_W'(cap_reg);
    assign cap_eff   = (cap_w > lfu_pkg::CMP_W'(lfu_pkg::MAX_ENTRIES)) ?
                       lfu_pkg::CMP_W'(lfu_pkg::MAX_ENTRIES) : cap_w;
    assign cap_zero  = (cap_reg == '0);
    assign do_touch  = found && (!is_put || !cap_zero);
    assign do_insert = !found && is_put && !cap_zero;
    assign evict     = do_insert && (lfu_pkg::CMP_W'(fill) >= cap_eff) && (|valid_reg);
    assign slot_oh   = evict ? victim_oh : free_oh;

    always_comb begin
        result.hit         = found;
        result.read_value  = found ? rd_value : '0;
        result.evicted     = evict;
        result.evicted_key = evict ? victim_key : '0;
    end

    // Table update
    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        count_next = count_reg;
        rank_next  = rank_reg;
        for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
            if (do_touch) begin
                if (found_oh[i]) begin
                    rank_next[i] = '0;
                    if (count_reg[i] != '1) begin
                        count_next[i] = count_reg[i] + 1'b1;
                    end
                    if (is_put) begin
                        value_next[i] = in_item_reg.value;
                    end
                end else if (valid_reg[i] && rank_reg[i] < found_rank) begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end else if (do_insert) begin
                if (slot_oh[i]) begin
                    valid_next[i] = 1'b1;
                    key_next[i]   = in_item_reg.key;
                    value_next[i] = in_item_reg.value;
                    count_next[i] = lfu_pkg::CNT_W'(1);
                    rank_next[i]  = '0;
                end else if (valid_reg[i]) begin
                    // entries older than the victim close its gap, then all age by one
                    if (!(evict && rank_reg[i] > victim_rank)) begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (proceed) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed) begin
            key_reg   <= key_next;
            value_reg <= value_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

endmodule

// ===== src/lfu_victim_pick.sv =====
// Replacement victim pick: pairwise count/recency compare across all slots.
module lfu_victim_pick (
    input  lfu_pkg::slot_vec_t valid,
    input  lfu_pkg::cnt_arr_t  count,
    input  lfu_pkg::rank_arr_t rank,
    output lfu_pkg::slot_vec_t victim_oh
);

    // A slot is the victim when it beats every other valid slot:
    // lower count, or equal count and older (higher rank).
    always_comb begin
        logic beats_all;
        for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
            beats_all = 1'b1;
            for (int j = 0; j < lfu_pkg::MAX_ENTRIES; j++) begin
                if (j != i && valid[j]) begin
                    if (!((count[i] < count[j]) ||
                          (count[i] == count[j] && rank[i] > rank[j]))) begin
                        beats_all = 1'b0;
                    end
                end
            end
            victim_oh[i] = valid[i] && beats_all;
        end
    end

endmodule

// ===== src/lfu_checker.sv =====
// Port-level checks for the LFU cache, bound to the top level.
module lfu_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input lfu_pkg::in_item_t               s_item,
    input logic                            m_valid,
    input logic                            m_ready,
    input lfu_pkg::out_item_t              m_item,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [lfu_pkg::CFG_ADDR_W-1:0]  paddr,
    input logic [lfu_pkg::CFG_DATA_W-1:0]  pwdata,
    input logic [lfu_pkg::CFG_DATA_W-1:0]  prdata,
    input logic                            pready
);

    // A waiting input item holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("input item changed while waiting");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.hit && m_item.evicted))
        else $error("hit item reported an eviction");

    // Unused result fields read zero
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.hit || m_item.read_value == '0) &&
                    (m_item.evicted || m_item.evicted_key == '0))
        else $error("result field not zeroed");

    // Capacity reads back what was written
    a_cap_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready && paddr[lfu_pkg::CFG_ADDR_W-1:2] ==
            lfu_pkg::REG_CAPACITY
        |=> (paddr[lfu_pkg::CFG_ADDR_W-1:2] != lfu_pkg::REG_CAPACITY) ||
            (prdata == lfu_pkg::CFG_DATA_W'($past(pwdata[lfu_pkg::CAP_W-1:0]))))
        else $error("capacity read back differs");

endmodule

bind lfu_cache_with_lru_tiebreak_unit lfu_checker u_lfu_checker (.*);
